### src/aes128_cbc_encrypt_core_macros.svh
// Assertion macros shared by the AES-128 CBC encryption core.
`ifndef AES128_CBC_ENCRYPT_CORE_MACROS_SVH
`define AES128_CBC_ENCRYPT_CORE_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Asserts that an antecedent implies a consequent in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/aes_pkg.sv
// Package with AES-128 constants, types and round functions.
package aes_pkg;

  localparam int unsigned ROUNDS = 10;
  localparam int unsigned TOTAL_WORDS = 4 * (ROUNDS + 1);
  localparam int unsigned RK_AW = $clog2(TOTAL_WORDS);
  localparam int unsigned RND_W = $clog2(ROUNDS + 1);

  localparam int unsigned IN_W = 129;
  localparam int unsigned OUT_W = 128;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 8'd3;

  typedef logic [31:0] word_t;
  typedef logic [127:0] block_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic word_t sub_word(input word_t w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // Byte n of the block sits in bits 127-8n down to 120-8n.
  function automatic block_t sub_shift(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

endpackage

### src/aes_if.sv
// Valid/ready channel interfaces for data and configuration.
interface aes_in_if
  import aes_pkg::*;
(input logic clk);
  logic valid;
  logic ready;
  logic [IN_W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface aes_out_if
  import aes_pkg::*;
(input logic clk);
  logic valid;
  logic ready;
  logic [OUT_W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface aes_cfg_if
  import aes_pkg::*;
(input logic clk);
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/aes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module aes_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 44
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/aes_round.sv
// Round datapath: applies one AES round to the state and adds a round key; the initial round only adds the key.
module aes_round
  import aes_pkg::*;
(
  input  block_t     state_in,
  input  logic [127:0] round_key,
  input  logic       initial_round,
  input  logic       final_round,
  output block_t     state_out
);
  block_t ss;
  block_t mc;

  always_comb begin
    ss = sub_shift(state_in);
    mc = mix_columns(ss);
    if (initial_round) begin
      state_out = state_in ^ round_key;
    end else if (final_round) begin
      state_out = ss ^ round_key;
    end else begin
      state_out = mc ^ round_key;
    end
  end
endmodule

### src/aes128_cbc_encrypt_core.sv
// AES-128 CBC encryption core: key expansion into RAM, one round per four key-word reads.
// A key change adds an expansion pass, one key word per cycle, before the block.
// A new block is accepted only after the previous one has finished, as the round keys are read one word a cycle.
// A request is accepted while the previous result still waits in the output register.
// Synchronous active-low reset clears chain value, configuration registers, control state and key-ready flag.
`include "aes128_cbc_encrypt_core_macros.svh"
module aes128_cbc_encrypt_core
  import aes_pkg::*;
(
  input logic clk,
  input logic rst_n,
  aes_in_if.sink     in_ch,
  aes_out_if.source  out_ch,
  aes_cfg_if.sink    cfg_ch
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXP  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [RK_AW-1:0] LAST_WORD = RK_AW'(TOTAL_WORDS - 1);

  logic [1:0] state_r, state_nxt;
  logic [63:0] key_high_r, key_low_r, iv_high_r, iv_low_r;
  logic keys_ready_r;
  block_t chain_r;
  block_t data_r;
  logic [RK_AW-1:0] cnt_r;
  word_t w0_r, w1_r, w2_r, w3_r;
  logic [7:0] rc_r;
  logic [127:0] out_r;
  logic out_valid_r;
  logic [RND_W-1:0] rnd_r;
  logic [1:0] col_r;
  logic [95:0] rk_r;
  logic rd_valid_r;

  logic ram_we;
  logic [RK_AW-1:0] ram_waddr, ram_raddr;
  word_t ram_wdata, ram_rdata;
  word_t new_w;
  word_t key_w;
  block_t round_out;
  logic in_acc;
  logic cfg_acc;
  logic round_step;
  logic last_round;
  logic out_stall;
  logic out_load;

  assign in_ch.ready = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = out_r;

  assign round_step = (state_r == ST_RUN) && rd_valid_r && (col_r == 2'd3);
  assign last_round = (rnd_r == RND_W'(ROUNDS));
  assign out_stall = out_valid_r && !out_ch.ready;
  assign out_load = ((round_step && last_round) || (state_r == ST_DONE)) && !out_stall;

  assign ram_we = (state_r == ST_EXP);
  assign ram_waddr = cnt_r;
  assign ram_raddr = cnt_r;

  aes_ram #(.WIDTH(32), .DEPTH(TOTAL_WORDS)) u_rk_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // The first four words come from the key; later ones from the last four written.
  always_comb begin
    case (cnt_r[1:0])
      2'd0: key_w = key_high_r[63:32];
      2'd1: key_w = key_high_r[31:0];
      2'd2: key_w = key_low_r[63:32];
      default: key_w = key_low_r[31:0];
    endcase
    if (cnt_r[1:0] == 2'd0) begin
      new_w = w0_r ^ sub_word({w3_r[23:0], w3_r[31:24]}) ^ {rc_r, 24'd0};
    end else begin
      new_w = w0_r ^ w3_r;
    end
    ram_wdata = (cnt_r[RK_AW-1:2] == '0) ? key_w : new_w;
  end

  aes_round u_round (
    .state_in(data_r), .round_key({rk_r, ram_rdata}),
    .initial_round(rnd_r == '0),
    .final_round(last_round),
    .state_out(round_out)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = keys_ready_r ? ST_RUN : ST_EXP;
      ST_EXP: if (cnt_r == LAST_WORD) state_nxt = ST_RUN;
      ST_RUN: if (round_step && last_round) state_nxt = out_stall ? ST_DONE : ST_IDLE;
      ST_DONE: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // In ST_RUN one key word is read per cycle; every fourth word completes a round key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_high_r <= '0;
      key_low_r <= '0;
      iv_high_r <= '0;
      iv_low_r <= '0;
      keys_ready_r <= 1'b0;
      chain_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      rnd_r <= '0;
      col_r <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_valid_r <= (state_r == ST_RUN);
      if (out_load) begin
        out_r <= (state_r == ST_DONE) ? data_r : round_out;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_ch.index)
          REG_KEY_HIGH: begin key_high_r <= cfg_ch.data; keys_ready_r <= 1'b0; end
          REG_KEY_LOW: begin key_low_r <= cfg_ch.data; keys_ready_r <= 1'b0; end
          REG_IV_HIGH: iv_high_r <= cfg_ch.data;
          REG_IV_LOW: iv_low_r <= cfg_ch.data;
          default: ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            data_r <= in_ch.payload[IN_W-1:1]
                      ^ (in_ch.payload[0] ? {iv_high_r, iv_low_r} : chain_r);
            rc_r <= 8'h01;
            cnt_r <= '0;
            rnd_r <= '0;
            col_r <= '0;
          end
        end
        ST_EXP: begin
          w0_r <= w1_r;
          w1_r <= w2_r;
          w2_r <= w3_r;
          w3_r <= ram_wdata;
          if (cnt_r[RK_AW-1:2] != '0 && cnt_r[1:0] == 2'd0) rc_r <= xtime(rc_r);
          if (cnt_r == LAST_WORD) begin
            keys_ready_r <= 1'b1;
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_RUN: begin
          if (cnt_r != LAST_WORD) cnt_r <= cnt_r + 1'b1;
          if (rd_valid_r) begin
            rk_r <= {rk_r[63:0], ram_rdata};
            col_r <= col_r + 1'b1;
          end
          if (round_step) begin
            data_r <= round_out;
            if (last_round) begin
              chain_r <= round_out;
            end else begin
              rnd_r <= rnd_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `AES_ASSERT_IMP(a_busy_in, clk, rst_n, state_r != ST_IDLE, !in_ch.ready, "input open while busy")
  `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid_r, "result dropped")
  `AES_ASSERT_NEXT(a_out_keep, clk, rst_n, out_stall, $stable(out_r), "result changed")
  `AES_ASSERT_IMP(a_run_keys, clk, rst_n, state_r == ST_RUN, keys_ready_r, "round keys stale")
  `AES_ASSERT_IMP(a_cfg_idle, clk, rst_n, cfg_acc, state_r == ST_IDLE, "write while busy")
endmodule

### sim/aes128_cbc_encrypt_core_tb.sv
// Self-checking testbench for the AES-128 CBC encryption core with a built-in predictor.
`timescale 1ns / 1ps

module aes128_cbc_encrypt_core_tb;
  import aes_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam longint unsigned CYCLE_LIMIT = 1000000;
  localparam logic [7:0] REG_UNUSED = 8'd9;
  localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        first_block;
  } plain_req_t;

  logic clk;
  logic rst_n;

  aes_in_if in_if (clk);
  aes_out_if out_if (clk);
  aes_cfg_if cfg_if (clk);

  aes128_cbc_encrypt_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  plain_req_t pending_q[$];
  block_t cipher_q[$];

  logic [7:0] sbox_lut [256];
  logic [63:0] key_hi_m, key_lo_m, iv_hi_m, iv_lo_m;
  block_t chain_m;
  word_t rkey_m [TOTAL_WORDS];
  logic rkey_valid_m;

  int unsigned errors;
  int unsigned sent_cnt;
  int unsigned cipher_cnt;
  int unsigned cfg_cnt;
  int unsigned first_cnt;
  longint unsigned cycles;
  int burst_left;
  int gap_left;
  int ready_pct;
  int hold_left;
  bit hold_done;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // The S-box is derived from the field inverse and the affine map.
  function automatic void build_sbox();
    logic [7:0] inv;
    logic [7:0] r;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) begin
        if (gf_mul(a[7:0], b[7:0]) == 8'h01) inv = b[7:0];
      end
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_lut[a] = r;
    end
  endfunction

  function automatic void expand_round_keys();
    word_t t;
    logic [7:0] rc;
    rc = 8'h01;
    rkey_m[0] = key_hi_m[63:32];
    rkey_m[1] = key_hi_m[31:0];
    rkey_m[2] = key_lo_m[63:32];
    rkey_m[3] = key_lo_m[31:0];
    for (int i = 4; i < TOTAL_WORDS; i++) begin
      t = rkey_m[i - 1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_lut[t[31:24]], sbox_lut[t[23:16]], sbox_lut[t[15:8]], sbox_lut[t[7:0]]}
            ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      rkey_m[i] = rkey_m[i - 4] ^ t;
    end
    rkey_valid_m = 1'b1;
  endfunction

  function automatic block_t cbc_encrypt_block(input plain_req_t req);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    word_t w;
    block_t blk;
    if (!rkey_valid_m) expand_round_keys();
    if (req.first_block) chain_m = {iv_hi_m, iv_lo_m};
    blk = {req.plain_high, req.plain_low} ^ chain_m;
    for (int n = 0; n < 16; n++) s[n] = blk[127 - 8 * n -: 8];
    for (int rnd = 0; rnd <= ROUNDS; rnd++) begin
      if (rnd > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[4 * c + r] = sbox_lut[s[4 * ((c + r) % 4) + r]];
        s = t;
      end
      if (rnd > 0 && rnd < ROUNDS) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
          all = a0 ^ a1 ^ a2 ^ a3;
          s[4 * c]     = a0 ^ all ^ gf_mul(a0 ^ a1, 8'h02);
          s[4 * c + 1] = a1 ^ all ^ gf_mul(a1 ^ a2, 8'h02);
          s[4 * c + 2] = a2 ^ all ^ gf_mul(a2 ^ a3, 8'h02);
          s[4 * c + 3] = a3 ^ all ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (int c = 0; c < 4; c++) begin
        w = rkey_m[rnd * 4 + c];
        for (int r = 0; r < 4; r++) s[4 * c + r] = s[4 * c + r] ^ w[31 - 8 * r -: 8];
      end
    end
    for (int n = 0; n < 16; n++) blk[127 - 8 * n -: 8] = s[n];
    chain_m = blk;
    return blk;
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 64'h0;
    if (pick == 1) return ONES;
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_plain(input logic fb, input logic [63:0] hi,
                                      input logic [63:0] lo);
    plain_req_t req;
    req.first_block = fb;
    req.plain_high = hi;
    req.plain_low = lo;
    pending_q.push_back(req);
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_KEY_HIGH: begin key_hi_m = value; rkey_valid_m = 1'b0; end
      REG_KEY_LOW:  begin key_lo_m = value; rkey_valid_m = 1'b0; end
      REG_IV_HIGH:  iv_hi_m = value;
      REG_IV_LOW:   iv_lo_m = value;
      default: ;
    endcase
    cfg_cnt++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_if.valid || cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.payload <= '0;
      burst_left <= 4;
      gap_left <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_q.size() != 0) begin
        in_if.payload <= pending_q.pop_front();
        in_if.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall density that changes during the run, plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_pct <= 100;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (cycles % 64 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
      if (!hold_done && sent_cnt >= 400) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      cipher_q.push_back(cbc_encrypt_block(plain_req_t'(in_if.payload)));
      sent_cnt++;
      if (in_if.payload[0]) first_cnt++;
    end
  end

  always @(posedge clk) begin
    block_t exp_blk;
    if (rst_n && out_if.valid && out_if.ready) begin
      cipher_cnt++;
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected ciphertext %h", $time, out_if.payload);
        errors++;
      end else begin
        exp_blk = cipher_q.pop_front();
        if (out_if.payload[127:64] !== exp_blk[127:64]) begin
          $display("%0t: cipher_high expected %h actual %h", $time, exp_blk[127:64],
                   out_if.payload[127:64]);
          errors++;
        end
        if (out_if.payload[63:0] !== exp_blk[63:0]) begin
          $display("%0t: cipher_low expected %h actual %h", $time, exp_blk[63:0],
                   out_if.payload[63:0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d requests still awaiting a ciphertext", $time,
               cipher_q.size());
      $display("aes128_cbc_encrypt_core_tb: errors");
      $finish;
    end
  end

  initial begin
    int n_msgs;
    int msg_len;
    errors = 0;
    sent_cnt = 0;
    cipher_cnt = 0;
    cfg_cnt = 0;
    first_cnt = 0;
    cycles = 0;
    key_hi_m = '0; key_lo_m = '0; iv_hi_m = '0; iv_lo_m = '0;
    chain_m = '0;
    rkey_valid_m = 1'b0;
    for (int i = 0; i < TOTAL_WORDS; i++) rkey_m[i] = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    rst_n = 1'b0;
    build_sbox();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A chain that never started runs from the zero reset value and the zero key.
    queue_plain(1'b0, 64'h0, 64'h0);
    queue_plain(1'b0, ONES, ONES);
    queue_plain(1'b1, 64'h0123_4567_89ab_cdef, ONES);
    wait_idle();

    write_reg(REG_KEY_HIGH, 64'h0001_0203_0405_0607);
    write_reg(REG_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
    write_reg(REG_IV_HIGH, 64'h0);
    write_reg(REG_IV_LOW, 64'h0);
    queue_plain(1'b1, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    queue_plain(1'b0, 64'h0, ONES);
    queue_plain(1'b0, ONES, 64'h0);
    queue_plain(1'b1, ONES, ONES);
    queue_plain(1'b0, 64'h8000_0000_0000_0001, 64'h5555_aaaa_5555_aaaa);
    wait_idle();

    // Key change in the middle of a message keeps the chain.
    write_reg(REG_KEY_HIGH, ONES);
    write_reg(REG_KEY_LOW, ONES);
    queue_plain(1'b0, 64'hdead_beef_0000_ffff, 64'h1);
    queue_plain(1'b0, 64'h0, 64'h0);
    wait_idle();

    // A new IV takes effect only at the next message start.
    write_reg(REG_IV_HIGH, ONES);
    write_reg(REG_IV_LOW, ONES);
    write_reg(REG_UNUSED, 64'h1234_5678_9abc_def0);
    queue_plain(1'b0, 64'h0, 64'h0);
    queue_plain(1'b1, 64'h0, 64'h0);
    queue_plain(1'b0, ONES, ONES);
    wait_idle();

    while (sent_cnt < RANDOM_ITEMS + 16) begin
      if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_HIGH, rand_word());
      if ($urandom_range(0, 2) != 0) write_reg(REG_KEY_LOW, rand_word());
      if ($urandom_range(0, 1) != 0) write_reg(REG_IV_HIGH, rand_word());
      if ($urandom_range(0, 1) != 0) write_reg(REG_IV_LOW, rand_word());
      if ($urandom_range(0, 7) == 0) write_reg(8'($urandom_range(4, 255)), rand_word());
      n_msgs = $urandom_range(1, 6);
      for (int m = 0; m < n_msgs; m++) begin
        msg_len = $urandom_range(1, 30);
        for (int k = 0; k < msg_len; k++) begin
          queue_plain((k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 15) == 0),
                      rand_word(), rand_word());
        end
      end
      wait_idle();
    end

    $display("Encrypted %0d requests (%0d message starts), checked %0d ciphertexts,",
             sent_cnt, first_cnt, cipher_cnt);
    $display("with %0d register writes across key and IV changes and output stalls.", cfg_cnt);
    if (errors == 0) begin
      $display("aes128_cbc_encrypt_core_tb: clean");
    end else begin
      $display("aes128_cbc_encrypt_core_tb: errors");
    end
    $finish;
  end

endmodule
